// ===== hw/rtl/ugns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugns_pkg: shared types and constants of the uniform grid neighbour store
// Request modes, register indexes, command format between the front and
// back parts, and configuration reset values.
// ----------------------------------------------------------------------------
package ugns_pkg;

	// Fixed field widths of the request and result channels
	localparam int FIELD_W    = 16;
	localparam int POS_W      = 16;
	localparam int INV_W      = 16;
	localparam int DIM_REG_W  = 7;
	localparam int CELL_ARG_W = 6;
	localparam int SPAN_W     = 3;
	localparam int REACH_W    = 2;
	localparam int MODE_W     = 2;

	// Coordinates in a command cover the largest supported grid (256 cells)
	localparam int COORD_W    = 8;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// Configuration reset values
	localparam logic [INV_W-1:0]     INV_CELL_SIZE_RST = 16'd4096;
	localparam logic [DIM_REG_W-1:0] GRID_WIDTH_RST    = 7'd64;
	localparam logic [DIM_REG_W-1:0] GRID_HEIGHT_RST   = 7'd64;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_RECT  = 2'd2,
		MODE_NEIGH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_INV_CELL_SIZE = 2'd0,
		REG_GRID_WIDTH    = 2'd1,
		REG_GRID_HEIGHT   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_SCAN  = 2'd1,
		CMD_NONE  = 2'd2
	} cmd_kind_t;

	typedef enum logic [2:0] {
		BK_CLEAR = 3'd0,
		BK_IDLE  = 3'd1,
		BK_SCAN  = 3'd2,
		BK_DRAIN = 3'd3,
		BK_FLUSH = 3'd4
	} back_state_t;

	typedef struct packed {
		logic [INV_W-1:0]     inv_cell_size;
		logic [DIM_REG_W-1:0] grid_width;
		logic [DIM_REG_W-1:0] grid_height;
	} cfg_t;

	// One classified request: a cell write, a window scan or an empty gather
	typedef struct packed {
		cmd_kind_t          kind;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic               skip_centre;
		logic               report_all;
		logic [FIELD_W-1:0] wdata;
	} cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ugns_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugns_if: request and result channels of the grid store
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ugns_query_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] index_value;
	logic [5:0]  cell_x;
	logic [5:0]  cell_y;
	logic [2:0]  span_w;
	logic [2:0]  span_h;
	logic [1:0]  reach;

	modport source (
		output valid, mode, pos_x, pos_y, index_value, cell_x, cell_y,
		       span_w, span_h, reach,
		input  ready
	);
	modport sink (
		input  valid, mode, pos_x, pos_y, index_value, cell_x, cell_y,
		       span_w, span_h, reach,
		output ready
	);
endinterface

interface ugns_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] found_index;
	logic        hit;
	logic        last;

	modport source (output valid, found_index, hit, last, input ready);
	modport sink   (input valid, found_index, hit, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ugns_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugns_front: request intake and classification
// Maps positions to cells (multiply stage, clamp stage) and turns each
// request into a command with a clamped scan window.
// ----------------------------------------------------------------------------
module ugns_front #(
	parameter int GRID_DIM = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ugns_pkg::cfg_t    cfg,
	input  logic              en,
	ugns_query_if.sink        query,
	output ugns_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready
);

	localparam int CW = $clog2(GRID_DIM);
	localparam int EW = (CW + 2 > 9) ? CW + 2 : 9;
	localparam int PW = 2 * ugns_pkg::POS_W;

	// Last column and row in use, size registers clamped to 1..GRID_DIM
	logic [EW-1:0] dim_e, gw_e, gh_e, wm1_e, hm1_e;

	assign dim_e = EW'(GRID_DIM);
	assign gw_e  = EW'(cfg.grid_width);
	assign gh_e  = EW'(cfg.grid_height);
	assign wm1_e = (gw_e == '0) ? '0 : ((gw_e > dim_e) ? dim_e - EW'(1) : gw_e - EW'(1));
	assign hm1_e = (gh_e == '0) ? '0 : ((gh_e > dim_e) ? dim_e - EW'(1) : gh_e - EW'(1));

	// Stage control
	logic v_s1, v_s2;
	logic s2_free, s1_free, ld1;

	assign s2_free     = !v_s2 || cmd_ready;
	assign s1_free     = !v_s1 || s2_free;
	assign query.ready = en && s1_free;
	assign ld1         = query.valid && query.ready;
	assign cmd_valid   = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ld1 || (v_s1 && !s2_free);
			v_s2 <= (v_s1 && s2_free) || (v_s2 && !cmd_ready);
		end
	end

	// Stage 1: position times cells per unit, keep the integer cell part
	logic [PW-1:0] prod_x, prod_y;

	assign prod_x = PW'(query.pos_x) * PW'(cfg.inv_cell_size);
	assign prod_y = PW'(query.pos_y) * PW'(cfg.inv_cell_size);

	ugns_pkg::mode_t                      mode_s1;
	logic [ugns_pkg::POS_W-1:0]           cx_s1, cy_s1;
	logic [ugns_pkg::FIELD_W-1:0]         idx_s1;
	logic [ugns_pkg::CELL_ARG_W-1:0]      cellx_s1, celly_s1;
	logic [ugns_pkg::SPAN_W-1:0]          spanw_s1, spanh_s1;
	logic [ugns_pkg::REACH_W-1:0]         reach_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			mode_s1  <= ugns_pkg::mode_t'(query.mode);
			cx_s1    <= prod_x[PW-1:ugns_pkg::POS_W];
			cy_s1    <= prod_y[PW-1:ugns_pkg::POS_W];
			idx_s1   <= query.index_value;
			cellx_s1 <= query.cell_x;
			celly_s1 <= query.cell_y;
			spanw_s1 <= query.span_w;
			spanh_s1 <= query.span_h;
			reach_s1 <= query.reach;
		end
	end

	// Stage 2: saturate the cell coordinate to the last column / row
	logic [CW-1:0] px_n, py_n;

	assign px_n = (cx_s1 > ugns_pkg::POS_W'(wm1_e)) ? CW'(wm1_e) : CW'(cx_s1);
	assign py_n = (cy_s1 > ugns_pkg::POS_W'(hm1_e)) ? CW'(hm1_e) : CW'(cy_s1);

	ugns_pkg::mode_t                      mode_s2;
	logic [CW-1:0]                        px_s2, py_s2;
	logic [ugns_pkg::FIELD_W-1:0]         idx_s2;
	logic [ugns_pkg::CELL_ARG_W-1:0]      cellx_s2, celly_s2;
	logic [ugns_pkg::SPAN_W-1:0]          spanw_s2, spanh_s2;
	logic [ugns_pkg::REACH_W-1:0]         reach_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && s2_free) begin
			mode_s2  <= mode_s1;
			px_s2    <= px_n;
			py_s2    <= py_n;
			idx_s2   <= idx_s1;
			cellx_s2 <= cellx_s1;
			celly_s2 <= celly_s1;
			spanw_s2 <= spanw_s1;
			spanh_s2 <= spanh_s1;
			reach_s2 <= reach_s1;
		end
	end

	// Command build: window bounds clamped to the grid
	logic [EW-1:0] pxe, pye, re, rx0, rx1, ry0, ry1, nx0, nx1, ny0, ny1;

	always_comb begin
		pxe = EW'(px_s2);
		pye = EW'(py_s2);
		re  = EW'(reach_s2);
		// rectangle
		rx0 = EW'(cellx_s2);
		ry0 = EW'(celly_s2);
		rx1 = rx0 + EW'(spanw_s2);
		ry1 = ry0 + EW'(spanh_s2);
		if (rx1 > wm1_e) rx1 = wm1_e;
		if (ry1 > hm1_e) ry1 = hm1_e;
		// neighbour window, clamped at zero and at the last column / row
		nx0 = (pxe >= re) ? pxe - re : '0;
		ny0 = (pye >= re) ? pye - re : '0;
		nx1 = pxe + re;
		ny1 = pye + re;
		if (nx1 > wm1_e) nx1 = wm1_e;
		if (ny1 > hm1_e) ny1 = hm1_e;

		cmd             = '0;
		cmd.kind        = ugns_pkg::CMD_SCAN;
		cmd.wdata       = idx_s2;
		cmd.cx          = ugns_pkg::COORD_W'(px_s2);
		cmd.cy          = ugns_pkg::COORD_W'(py_s2);
		unique case (mode_s2)
			ugns_pkg::MODE_WRITE: begin
				cmd.kind = ugns_pkg::CMD_WRITE;
				cmd.x0   = ugns_pkg::COORD_W'(px_s2);
				cmd.y0   = ugns_pkg::COORD_W'(py_s2);
			end
			ugns_pkg::MODE_READ: begin
				cmd.x0         = ugns_pkg::COORD_W'(px_s2);
				cmd.x1         = ugns_pkg::COORD_W'(px_s2);
				cmd.y0         = ugns_pkg::COORD_W'(py_s2);
				cmd.y1         = ugns_pkg::COORD_W'(py_s2);
				cmd.report_all = 1'b1;
			end
			ugns_pkg::MODE_RECT: begin
				// rectangle starting off the grid holds nothing
				if (rx0 > wm1_e || ry0 > hm1_e) cmd.kind = ugns_pkg::CMD_NONE;
				cmd.x0 = ugns_pkg::COORD_W'(rx0);
				cmd.x1 = ugns_pkg::COORD_W'(rx1);
				cmd.y0 = ugns_pkg::COORD_W'(ry0);
				cmd.y1 = ugns_pkg::COORD_W'(ry1);
			end
			ugns_pkg::MODE_NEIGH: begin
				cmd.x0          = ugns_pkg::COORD_W'(nx0);
				cmd.x1          = ugns_pkg::COORD_W'(nx1);
				cmd.y0          = ugns_pkg::COORD_W'(ny0);
				cmd.y1          = ugns_pkg::COORD_W'(ny1);
				cmd.skip_centre = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ugns_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugns_cmd_fifo: short command queue between front and back
// Register-based FIFO; lets either side stall on its own.
// ----------------------------------------------------------------------------
module ugns_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ugns_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ugns_pkg::cmd_t pop_data
);

	localparam int DEPTH = ugns_pkg::CMDQ_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	ugns_pkg::cmd_t ent_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [NW-1:0]  cnt_q;
	logic           push, pop;

	assign push_ready = (cnt_q != NW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)      cnt_q <= cnt_q + NW'(1);
			else if (pop && !push) cnt_q <= cnt_q - NW'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ugns_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugns_back: cell store and scan engine
// Holds the cell memory, clears it after reset, performs writes and walks
// scan windows one cell per cycle while results drain, emitting hits with the final one marked.
// ----------------------------------------------------------------------------
module ugns_back #(
	parameter int GRID_DIM   = 64,
	parameter int INDEX_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ugns_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	ugns_result_if.source  result,
	output logic           clearing
);

	localparam int CW    = $clog2(GRID_DIM);
	localparam int IB    = INDEX_BITS;
	localparam int DEPTH = GRID_DIM * GRID_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [IB-1:0] EMPTY = '1;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
		return AW'(y) * AW'(GRID_DIM) + AW'(x);
	endfunction

	ugns_pkg::back_state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic [CW-1:0] x_q, y_q, x0_q, x1_q, y1_q, cx_q, cy_q;
	logic          skip_q, rep_q;

	logic [IB-1:0] mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [IB-1:0] mem_wd;

	logic [IB-1:0] rd_s1;
	logic          rv_s1, rlast_s1, rskip_s1;

	logic                         pend_v_q, pend_hit_q;
	logic [IB-1:0]                pend_idx_q;
	logic                         out_v_q, out_hit_q, out_last_q;
	logic [ugns_pkg::FIELD_W-1:0] out_idx_q;

	logic load, issue, at_end, r_hit, take, cons, out_free, emit_mid, emit_fin;

	assign clearing  = (state_q == ugns_pkg::BK_CLEAR);
	assign at_end    = (x_q == x1_q) && (y_q == y1_q);
	assign out_free  = !out_v_q || result.ready;

	// Read data handling: a taken cell goes to the pending slot, pushing
	// the previous one out as a non-final result
	assign r_hit    = (rd_s1 != EMPTY);
	assign take     = rv_s1 && !rskip_s1 && (r_hit || rep_q);
	assign cons     = rv_s1 && (!take || !pend_v_q || out_free);
	assign emit_mid = cons && take && pend_v_q;

	// Sequencer
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wa    = cell_addr(cmd.x0[CW-1:0], cmd.y0[CW-1:0]);
		mem_wd    = IB'(cmd.wdata);
		cmd_ready = 1'b0;
		load      = 1'b0;
		issue     = 1'b0;
		emit_fin  = 1'b0;
		unique case (state_q)
			ugns_pkg::BK_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = EMPTY;
				if (clr_q == AW'(DEPTH - 1)) state_d = ugns_pkg::BK_IDLE;
			end
			ugns_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_ready = 1'b1;
					unique case (cmd.kind)
						ugns_pkg::CMD_WRITE: mem_we = 1'b1;
						ugns_pkg::CMD_SCAN: begin
							load    = 1'b1;
							state_d = ugns_pkg::BK_SCAN;
						end
						ugns_pkg::CMD_NONE: state_d = ugns_pkg::BK_FLUSH;
						default: state_d = ugns_pkg::BK_IDLE;
					endcase
				end
			end
			ugns_pkg::BK_SCAN: begin
				issue = !rv_s1 || cons;
				if (issue && at_end) state_d = ugns_pkg::BK_DRAIN;
			end
			ugns_pkg::BK_DRAIN: begin
				if (cons && rlast_s1) state_d = ugns_pkg::BK_FLUSH;
			end
			ugns_pkg::BK_FLUSH: begin
				if (out_free) begin
					emit_fin = 1'b1;
					state_d  = ugns_pkg::BK_IDLE;
				end
			end
			default: state_d = ugns_pkg::BK_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ugns_pkg::BK_CLEAR;
			clr_q    <= '0;
			rv_s1    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ugns_pkg::BK_CLEAR) clr_q <= clr_q + AW'(1);
			if (issue)     rv_s1 <= 1'b1;
			else if (cons) rv_s1 <= 1'b0;
			if (cons && take)  pend_v_q <= 1'b1;
			else if (emit_fin) pend_v_q <= 1'b0;
			if (emit_mid || emit_fin) out_v_q <= 1'b1;
			else if (result.ready)    out_v_q <= 1'b0;
		end
	end

	// Window walk, row by row, left to right
	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= cmd.x0[CW-1:0];
			y_q    <= cmd.y0[CW-1:0];
			x0_q   <= cmd.x0[CW-1:0];
			x1_q   <= cmd.x1[CW-1:0];
			y1_q   <= cmd.y1[CW-1:0];
			cx_q   <= cmd.cx[CW-1:0];
			cy_q   <= cmd.cy[CW-1:0];
			skip_q <= cmd.skip_centre;
			rep_q  <= cmd.report_all;
		end else if (issue) begin
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + CW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
		if (issue) begin
			rlast_s1 <= at_end;
			rskip_s1 <= skip_q && (x_q == cx_q) && (y_q == cy_q);
		end
		if (cons && take) begin
			pend_idx_q <= rd_s1;
			pend_hit_q <= r_hit;
		end
	end

	// Cell memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (issue)  rd_s1 <= mem[cell_addr(x_q, y_q)];
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit_mid) begin
			out_idx_q  <= ugns_pkg::FIELD_W'(pend_idx_q);
			out_hit_q  <= pend_hit_q;
			out_last_q <= 1'b0;
		end else if (emit_fin) begin
			out_idx_q  <= pend_v_q ? ugns_pkg::FIELD_W'(pend_idx_q) : ugns_pkg::FIELD_W'(EMPTY);
			out_hit_q  <= pend_v_q && pend_hit_q;
			out_last_q <= 1'b1;
		end
	end

	assign result.valid       = out_v_q;
	assign result.found_index = out_idx_q;
	assign result.hit         = out_hit_q;
	assign result.last        = out_last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/uniform_grid_neighbour_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_grid_neighbour_store: background grid of point indexes
// Requests arrive on the query channel (write cell, read cell, gather a
// rectangle, gather neighbours of a position); results leave on the result
// channel, one request after another, the final one of a request marked by
// last. Configuration must be written through the APB-style port only while
// no request is in flight; the block itself does not enforce this.
// Flow: a request passes a multiply stage, a clamp stage and the command
// queue before the back end takes it. A gather reads its window cell by
// cell through the single read port of the cell memory. The front keeps
// accepting requests while the back works, until the two-entry command
// queue and the front stages are full.
// Reset: the memory is swept to empty, one cell a cycle, over all of its
// GRID_DIM*GRID_DIM cells (4096 by default); no request is taken during
// the sweep. A stalled result channel holds the output register and,
// behind it, the scan, the queue and finally the query channel.
// ----------------------------------------------------------------------------
module uniform_grid_neighbour_store #(
	parameter int GRID_DIM   = 64,
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ugns_query_if.sink    query,
	ugns_result_if.source result
);

	ugns_pkg::cfg_t cfg_q;
	ugns_pkg::cmd_t push_cmd, pop_cmd;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	logic           clearing;
	logic           cfg_wr;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_cell_size <= ugns_pkg::INV_CELL_SIZE_RST;
			cfg_q.grid_width    <= ugns_pkg::GRID_WIDTH_RST;
			cfg_q.grid_height   <= ugns_pkg::GRID_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (ugns_pkg::reg_idx_t'(paddr[3:2]))
				ugns_pkg::REG_INV_CELL_SIZE:
					cfg_q.inv_cell_size <= pwdata[ugns_pkg::INV_W-1:0];
				ugns_pkg::REG_GRID_WIDTH:
					cfg_q.grid_width <= pwdata[ugns_pkg::DIM_REG_W-1:0];
				ugns_pkg::REG_GRID_HEIGHT:
					cfg_q.grid_height <= pwdata[ugns_pkg::DIM_REG_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (ugns_pkg::reg_idx_t'(paddr[3:2]))
			ugns_pkg::REG_INV_CELL_SIZE: prdata = 32'(cfg_q.inv_cell_size);
			ugns_pkg::REG_GRID_WIDTH:    prdata = 32'(cfg_q.grid_width);
			ugns_pkg::REG_GRID_HEIGHT:   prdata = 32'(cfg_q.grid_height);
			default:                     prdata = '0;
		endcase
	end

	ugns_front #(
		.GRID_DIM (GRID_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.en        (!clearing),
		.query     (query),
		.cmd       (push_cmd),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready)
	);

	ugns_cmd_fifo u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_cmd)
	);

	ugns_back #(
		.GRID_DIM   (GRID_DIM),
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.result    (result),
		.clearing  (clearing)
	);

`ifndef NO_ASSERTIONS
	// No request enters while the memory sweep runs
	a_no_query_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(query.valid && query.ready))
		else $error("request accepted during memory clear");

	// No result can exist before the store is ready
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !result.valid)
		else $error("result presented during memory clear");

	// An empty result only ever ends a request
	a_miss_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> result.last)
		else $error("empty result not marked last");
`endif

endmodule
`default_nettype wire

// ===== test/tb_uniform_grid_neighbour_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uniform_grid_neighbour_store: self-checking bench of the grid store
// Drives write, read, rectangle and neighbour requests on the query channel
// and checks every result against a cell-accurate prediction of the store.
// A directed table covers edges and clamping. Random phases under several
// grid settings and handshake idle profiles follow.
// ----------------------------------------------------------------------------
module tb_uniform_grid_neighbour_store;
	import ugns_pkg::*;

	localparam int          GRID_DIM     = 64;
	localparam logic [15:0] EMPTY        = 16'hFFFF;
	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          TAIL_CYCLES  = 100;
	localparam int          LONG_HOLD    = 400;
	localparam int          PHASES       = 6;
	localparam int          PHASE_ITEMS  = 14;
	localparam int          DIRECTED_N   = 22;

	// Grid settings per random phase, extremes and out-of-range sizes included
	localparam logic [15:0] PHASE_INV [PHASES] = '{16'd4096, 16'd65535, 16'd4096,
		16'd0, 16'd20000, 16'd1};
	localparam logic [6:0] PHASE_W [PHASES] = '{7'd64, 7'd1, 7'd64, 7'd0, 7'd13, 7'd64};
	localparam logic [6:0] PHASE_H [PHASES] = '{7'd64, 7'd1, 7'd64, 7'd127, 7'd7, 7'd40};

	typedef struct packed {
		mode_t       mode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] index_value;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [2:0]  span_w;
		logic [2:0]  span_h;
		logic [1:0]  reach;
	} query_t;

	typedef struct packed {
		logic [15:0] found_index;
		logic        hit;
		logic        last;
	} grid_hit_t;

	// One directed row; fixed rows carry their single result inline
	typedef struct {
		mode_t       mode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] index_value;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [2:0]  span_w;
		logic [2:0]  span_h;
		logic [1:0]  reach;
		bit          fixed;
		logic [15:0] found;
		bit          hit;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ugns_query_if  query_ch ();
	ugns_result_if result_ch ();

	// Shadow of the store and its registers
	logic [15:0] cell_mem [GRID_DIM*GRID_DIM];
	logic [15:0] cfg_inv;
	logic [6:0]  cfg_w;
	logic [6:0]  cfg_h;

	grid_hit_t     pending_hits [$];
	directed_row_t directed_rows [DIRECTED_N];

	int          fail_count    = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hot_x, hot_y;

	uniform_grid_neighbour_store #(
		.GRID_DIM   (GRID_DIM),
		.INDEX_BITS (16)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.query   (query_ch),
		.result  (result_ch)
	);

	always #10 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_uniform_grid_neighbour_store: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic int unsigned dim_used(logic [6:0] v);
		if (v == 0) return 1;
		if (v > GRID_DIM) return GRID_DIM;
		return v;
	endfunction

	function automatic int unsigned pos_to_cell(logic [15:0] pos, int unsigned dim);
		logic [31:0] prod;
		prod = pos * cfg_inv;
		if (prod[31:16] > dim - 1) return dim - 1;
		return prod[31:16];
	endfunction

	// Append one expected result at the tail of the queue
	task automatic expect_result(input grid_hit_t h);
		pending_hits.insert(pending_hits.size(), h);
	endtask

	// Walk a window row by row; hold back each hit until the next so that
	// the final one can be marked last
	task automatic gather_cells(input int unsigned x0, input int unsigned x1,
		input int unsigned y0, input int unsigned y1, input bit skip_centre,
		input int unsigned cx, input int unsigned cy);
		grid_hit_t held;
		bit        have;
		int        n;
		logic [15:0] v;
		have = 1'b0;
		n = 0;
		for (int unsigned y = y0; y <= y1; y++) begin
			for (int unsigned x = x0; x <= x1; x++) begin
				v = cell_mem[y*GRID_DIM + x];
				if (!(skip_centre && x == cx && y == cy) && v != EMPTY && n < 64) begin
					if (have) expect_result(held);
					held = grid_hit_t'{v, 1'b1, 1'b0};
					have = 1'b1;
					n++;
				end
			end
		end
		if (have) begin
			held.last = 1'b1;
			expect_result(held);
		end else begin
			expect_result(grid_hit_t'{EMPTY, 1'b0, 1'b1});
		end
	endtask

	task automatic predict_query(input query_t q);
		int unsigned w, h, px, py, x0, x1, y0, y1, r;
		logic [15:0] v;
		w = dim_used(cfg_w);
		h = dim_used(cfg_h);
		px = pos_to_cell(q.pos_x, w);
		py = pos_to_cell(q.pos_y, h);
		case (q.mode)
			MODE_WRITE: cell_mem[py*GRID_DIM + px] = q.index_value;
			MODE_READ: begin
				v = cell_mem[py*GRID_DIM + px];
				expect_result(grid_hit_t'{v, v != EMPTY, 1'b1});
			end
			MODE_RECT: begin
				x0 = q.cell_x;
				y0 = q.cell_y;
				x1 = x0 + q.span_w;
				y1 = y0 + q.span_h;
				if (x0 >= w || y0 >= h) begin
					expect_result(grid_hit_t'{EMPTY, 1'b0, 1'b1});
				end else begin
					gather_cells(x0, (x1 > w - 1) ? w - 1 : x1, y0,
						(y1 > h - 1) ? h - 1 : y1, 1'b0, 0, 0);
				end
			end
			default: begin
				r = q.reach;
				x0 = (px >= r) ? px - r : 0;
				y0 = (py >= r) ? py - r : 0;
				x1 = (px + r > w - 1) ? w - 1 : px + r;
				y1 = (py + r > h - 1) ? h - 1 : py + r;
				gather_cells(x0, x1, y0, y1, 1'b1, px, py);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Random requests
	// ------------------------------------------------------------------
	// Smallest position that lands in cell c under the current scale
	function automatic logic [15:0] pos_for_cell(int unsigned c);
		longint unsigned p;
		if (cfg_inv == 0) return 16'($urandom);
		p = c;
		p = ((p << 16) + cfg_inv - 1) / cfg_inv;
		return (p > 65535) ? 16'hFFFF : p[15:0];
	endfunction

	function automatic query_t random_query();
		query_t      q;
		int unsigned roll, cx, cy;
		q.mode        = mode_t'($urandom_range(3));
		q.pos_x       = 16'($urandom);
		q.pos_y       = 16'($urandom);
		q.index_value = 16'($urandom);
		q.cell_x      = 6'($urandom);
		q.cell_y      = 6'($urandom);
		q.span_w      = 3'($urandom);
		q.span_h      = 3'($urandom);
		q.reach       = 2'($urandom);
		roll = $urandom_range(99);
		// noise: fully random fields
		if (roll < 10) return q;
		// otherwise aim at the hot region so gathers find entries
		q.pos_x = pos_for_cell(hot_x + $urandom_range(7));
		q.pos_y = pos_for_cell(hot_y + $urandom_range(7));
		cx = hot_x + $urandom_range(3);
		cy = hot_y + $urandom_range(3);
		q.cell_x = (cx > 63) ? 6'd63 : 6'(cx);
		q.cell_y = (cy > 63) ? 6'd63 : 6'(cy);
		if (roll < 45) begin
			q.mode = MODE_WRITE;
			if ($urandom_range(9) == 0) q.index_value = EMPTY;
		end else if (roll < 57) begin
			q.mode = MODE_READ;
		end else if (roll < 78) begin
			q.mode = MODE_RECT;
		end else begin
			q.mode = MODE_NEIGH;
		end
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Query channel driver
	// ------------------------------------------------------------------
	task automatic send_query(input query_t q);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			query_ch.valid <= 1'b0;
			@(negedge clk);
		end
		query_ch.mode        <= q.mode;
		query_ch.pos_x       <= q.pos_x;
		query_ch.pos_y       <= q.pos_y;
		query_ch.index_value <= q.index_value;
		query_ch.cell_x      <= q.cell_x;
		query_ch.cell_y      <= q.cell_y;
		query_ch.span_w      <= q.span_w;
		query_ch.span_h      <= q.span_h;
		query_ch.reach       <= q.reach;
		query_ch.valid       <= 1'b1;
		do @(posedge clk); while (!query_ch.ready);
	endtask

	task automatic issue_query(input query_t q);
		send_query(q);
		predict_query(q);
	endtask

	task automatic release_query();
		@(negedge clk);
		query_ch.valid <= 1'b0;
	endtask

	task automatic wait_all_results();
		while (pending_hits.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_INV_CELL_SIZE: cfg_inv = value[15:0];
			REG_GRID_WIDTH:    cfg_w   = value[6:0];
			default:           cfg_h   = value[6:0];
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask, rd;
		mask = (idx == REG_INV_CELL_SIZE) ? 32'h0000_FFFF : 32'h0000_007F;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if ((rd & mask) !== (value & mask)) begin
			$error("%s: expected %h, got %h", idx.name(), value & mask, rd & mask);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_grid(input logic [15:0] inv, input logic [6:0] w, input logic [6:0] h);
		write_reg(REG_INV_CELL_SIZE, {16'd0, inv});
		write_reg(REG_GRID_WIDTH, {25'd0, w});
		write_reg(REG_GRID_HEIGHT, {25'd0, h});
		check_reg(REG_INV_CELL_SIZE, {16'd0, inv});
		check_reg(REG_GRID_WIDTH, {25'd0, w});
		check_reg(REG_GRID_HEIGHT, {25'd0, h});
	endtask

	// ------------------------------------------------------------------
	// Result channel: ready pattern with an occasional long hold-off
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned holds_served;
		stall_left = 0;
		holds_served = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left = LONG_HOLD;
			end
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		grid_hit_t exp_hit;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_hits.size() == 0) begin
				$error("unexpected result: found_index %h hit %b last %b",
					result_ch.found_index, result_ch.hit, result_ch.last);
				fail_count++;
			end else begin
				exp_hit = pending_hits.pop_front();
				if (result_ch.found_index !== exp_hit.found_index) begin
					$error("found_index: expected %h, got %h", exp_hit.found_index,
						result_ch.found_index);
					fail_count++;
				end
				if (result_ch.hit !== exp_hit.hit) begin
					$error("hit: expected %b, got %b", exp_hit.hit, result_ch.hit);
					fail_count++;
				end
				if (result_ch.last !== exp_hit.last) begin
					$error("last: expected %b, got %b", exp_hit.last, result_ch.last);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		query_t        q;
		directed_row_t row;
		int unsigned   w, h;

		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		query_ch.valid       = 1'b0;
		query_ch.mode        = MODE_WRITE;
		query_ch.pos_x       = '0;
		query_ch.pos_y       = '0;
		query_ch.index_value = '0;
		query_ch.cell_x      = '0;
		query_ch.cell_y      = '0;
		query_ch.span_w      = '0;
		query_ch.span_h      = '0;
		query_ch.reach       = '0;

		foreach (cell_mem[i]) cell_mem[i] = EMPTY;
		cfg_inv = INV_CELL_SIZE_RST;
		cfg_w   = GRID_WIDTH_RST;
		cfg_h   = GRID_HEIGHT_RST;

		// Default scale: one cell per 16 position units, so cell = pos >> 4
		directed_rows = '{
			// empty store: read, largest rectangle and saturated neighbour window
			'{MODE_READ,  16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 1, EMPTY, 0},
			'{MODE_RECT,  16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd7, 3'd7, 2'd0, 1, EMPTY, 0},
			'{MODE_NEIGH, 16'hFFFF, 16'hFFFF, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd3, 1, EMPTY, 0},
			// populate corners and the top-left block
			'{MODE_WRITE, 16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_WRITE, 16'h0010, 16'h0000, 16'h1234, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_WRITE, 16'h0000, 16'h001F, 16'hA5A5, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_WRITE, 16'h0011, 16'h0012, 16'h5A5A, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_WRITE, 16'h03E0, 16'h03F0, 16'h0F0F, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_READ,  16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 1, 16'h0000, 1},
			'{MODE_READ,  16'h03F0, 16'h03FF, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 1, 16'hFFFE, 1},
			'{MODE_READ,  16'h001F, 16'h0010, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 1, 16'h5A5A, 1},
			'{MODE_RECT,  16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd1, 3'd1, 2'd0, 0, 16'h0, 0},
			// window clamped at zero and at the far edge, centre left out
			'{MODE_NEIGH, 16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd1, 0, 16'h0, 0},
			'{MODE_NEIGH, 16'hFFFF, 16'hFFFF, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd3, 0, 16'h0, 0},
			// rectangle running off the grid
			'{MODE_RECT,  16'h0000, 16'h0000, 16'h0000, 6'd60, 6'd60, 3'd7, 3'd7, 2'd0, 0, 16'h0, 0},
			'{MODE_RECT,  16'h0000, 16'h0000, 16'h0000, 6'd63, 6'd63, 3'd0, 3'd0, 2'd0, 1, 16'hFFFE, 1},
			// reach zero: only the centre, which is skipped
			'{MODE_NEIGH, 16'h0018, 16'h0018, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 1, EMPTY, 0},
			// writing the empty mark clears the cell
			'{MODE_WRITE, 16'h0000, 16'h0000, 16'hFFFF, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_READ,  16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd0, 1, EMPTY, 0},
			'{MODE_RECT,  16'h0000, 16'h0000, 16'h0000, 6'd0,  6'd0,  3'd2, 3'd0, 2'd0, 0, 16'h0, 0},
			'{MODE_NEIGH, 16'h0010, 16'h0010, 16'h0000, 6'd0,  6'd0,  3'd0, 3'd0, 2'd2, 0, 16'h0, 0}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		check_reg(REG_INV_CELL_SIZE, {16'd0, INV_CELL_SIZE_RST});
		check_reg(REG_GRID_WIDTH, {25'd0, GRID_WIDTH_RST});
		check_reg(REG_GRID_HEIGHT, {25'd0, GRID_HEIGHT_RST});

		// Directed table
		send_idle_pct = 15;
		recv_idle_pct = 60;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			q.mode        = row.mode;
			q.pos_x       = row.pos_x;
			q.pos_y       = row.pos_y;
			q.index_value = row.index_value;
			q.cell_x      = row.cell_x;
			q.cell_y      = row.cell_y;
			q.span_w      = row.span_w;
			q.span_h      = row.span_h;
			q.reach       = row.reach;
			if (row.fixed) begin
				send_query(q);
				expect_result(grid_hit_t'{row.found, row.hit, 1'b1});
			end else begin
				issue_query(q);
			end
		end

		// Random phases, each under its own grid setting
		for (int p = 0; p < PHASES; p++) begin
			release_query();
			wait_all_results();
			repeat (DRAIN_CYCLES) @(posedge clk);
			set_grid(PHASE_INV[p], PHASE_W[p], PHASE_H[p]);
			send_idle_pct = (p < 2) ? 15 : (p < 4) ? 60 : 0;
			recv_idle_pct = (p < 2) ? 60 : (p < 4) ? 15 : 0;
			w = dim_used(cfg_w);
			h = dim_used(cfg_h);
			hot_x = $urandom_range(w > 8 ? w - 8 : 0);
			hot_y = $urandom_range(h > 8 ? h - 8 : 0);

			// fill an 8x8 block, then gather all of it: a full result burst
			if (p == 2) begin
				for (int y = 0; y < 8; y++) begin
					for (int x = 0; x < 8; x++) begin
						q = '0;
						q.mode        = MODE_WRITE;
						q.pos_x       = pos_for_cell(hot_x + x);
						q.pos_y       = pos_for_cell(hot_y + y);
						q.index_value = 16'($urandom_range(16'hFFFE));
						issue_query(q);
					end
				end
				q = '0;
				q.mode   = MODE_RECT;
				q.cell_x = 6'(hot_x);
				q.cell_y = 6'(hot_y);
				q.span_w = 3'd7;
				q.span_h = 3'd7;
				issue_query(q);
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver holds off while requests keep coming
				if (p == 0 && n == 5) hold_requests++;
				// sender pauses until the block has emptied
				if (p == 3 && n == 9) begin
					release_query();
					wait_all_results();
				end
				issue_query(random_query());
			end
		end

		release_query();
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_uniform_grid_neighbour_store: PASS");
		else
			$display("tb_uniform_grid_neighbour_store: FAIL");
		$finish;
	end

endmodule
